### hw/rtl/lzwd_pkg.sv
// Package with the constants, codes and types of the LZ word decompressor.
`timescale 1ns / 1ps
package lzwd_pkg;
  localparam int unsigned OffsetBits = 10;
  localparam int unsigned MaxPrefix  = 24;
  localparam int unsigned HistDepth  = 1 << OffsetBits;
  localparam int unsigned AccW       = 25;
  localparam logic [30:0] EmitMax    = 31'h7fffffff;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_CTRL = 2'd1,
    CMD_LIT  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_PREFIX = 3'd2,
    ST_OFFSET = 3'd3,
    ST_KIND   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_FLAG, PH_LIT_PRE, PH_LIT_SUF, PH_LIT_RUN, PH_GRP_PRE, PH_GRP_SUF,
    PH_LEN_PRE, PH_LEN_SUF, PH_OFS, PH_COPY
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE, SQ_READ, SQ_OUT
  } seq_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] word;
  } in_t;

  typedef struct packed {
    logic        out_valid;
    logic [31:0] out_word;
    logic [2:0]  out_bytes;
    logic        last;
    logic [1:0]  need;
    logic [2:0]  status;
  } out_t;
endpackage

### hw/rtl/lzwd_if.sv
// Valid/ready channel interfaces for items, results and configuration.
`timescale 1ns / 1ps
interface lzwd_in_if;
  import lzwd_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzwd_out_if;
  import lzwd_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzwd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lzwd_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module lzwd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hw/rtl/lz_word_decompressor_unit.sv
// Top level of the LZ word decompressor.
`timescale 1ns / 1ps
// One item is taken per beat and gives one result beat. Each item is accepted
// while the block is idle, the decoder state is updated in the next cycle, and
// the result beat is offered in the cycle after that. The block is not ready
// again until that result beat is taken, so a stalled receiver adds its stall to
// every item. A history copy needs no extra state, because the history RAM read
// address is set up while the block waits for the item. Control bits are
// consumed one per tick, so a word costs a few items on average.
module lz_word_decompressor_unit (
  input logic clk_i,
  input logic rst_ni,
  lzwd_in_if.sink    in_if,
  lzwd_out_if.source out_if,
  lzwd_cfg_if.sink   cfg_if
);
  import lzwd_pkg::*;

  seq_e        seq_q, seq_d;
  in_t         item_q;
  out_t        res_q, res_d;
  logic [31:0] bytes_q;
  logic [31:0] ctrl_q, ctrl_d;
  logic [5:0]  left_q, left_d;
  phase_e      ph_q, ph_d;
  logic [4:0]  pre_q, pre_d;
  logic [AccW-1:0] acc_q, acc_d, grp_q, grp_d, run_q, run_d;
  logic [OffsetBits-1:0] ofs_q, ofs_d;
  logic [30:0] emit_q, emit_d;
  logic [2:0]  err_q, err_d;
  logic        ram_we;
  logic [OffsetBits-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        do_emit;
  logic [31:0] emit_w;

  logic [31:0] total;
  assign total = {2'b00, bytes_q[31:2]} + {31'd0, |bytes_q[1:0]};

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (seq_q == SQ_IDLE);
  assign out_if.valid = (seq_q == SQ_OUT);
  assign out_if.data  = res_q;

  lzwd_ram #(.Width(32), .Depth(HistDepth)) u_hist (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SQ_IDLE: if (in_if.valid) seq_d = SQ_READ;
      SQ_READ: seq_d = SQ_OUT;
      SQ_OUT:  if (out_if.ready) seq_d = SQ_IDLE;
      default: seq_d = SQ_IDLE;
    endcase
  end

  function automatic logic [1:0] want_f(phase_e p, logic [5:0] l, logic fin);
    if (fin) return CMD_TICK;
    if (p == PH_LIT_RUN) return CMD_LIT;
    if (p != PH_COPY && l == 6'd0) return CMD_CTRL;
    return CMD_TICK;
  endfunction

  always_comb begin
    logic        fin, fin2, bit_v;
    logic [1:0]  want;
    logic [4:0]  pdec;
    logic [AccW-1:0] acc_n, vm1;
    logic [OffsetBits-1:0] o;
    ctrl_d = ctrl_q; left_d = left_q; ph_d = ph_q; pre_d = pre_q; acc_d = acc_q;
    grp_d = grp_q; run_d = run_q; ofs_d = ofs_q; emit_d = emit_q; err_d = err_q;
    do_emit = 1'b0; emit_w = item_q.word; res_d = res_q;
    fin = (ph_q == PH_FLAG) && ({1'b0, emit_q} >= total);
    want = want_f(ph_q, left_q, fin);
    bit_v = ctrl_q[31];
    acc_n = {acc_q[AccW-2:0], bit_v};
    pdec = pre_q - 5'd1;
    vm1 = acc_n - {{(AccW-1){1'b0}}, 1'b1};
    o = acc_n[OffsetBits-1:0];
    if (err_q == 3'd0) begin
      if (item_q.command == CMD_CTRL || item_q.command == CMD_LIT) begin
        if (item_q.command != want) begin
          err_d = ST_KIND;
        end else if (item_q.command == CMD_CTRL) begin
          ctrl_d = item_q.word; left_d = 6'd32;
        end else begin
          do_emit = 1'b1;
          run_d = run_q - 1'b1;
          if (run_d == '0) ph_d = PH_FLAG;
        end
      end else if (item_q.command == CMD_TICK && !fin && want == CMD_TICK) begin
        if (ph_q == PH_COPY) begin
          do_emit = 1'b1; emit_w = ram_rdata;
          run_d = run_q - 1'b1;
          if (run_d == '0) begin
            grp_d = grp_q - 1'b1;
            if (grp_d != '0) begin pre_d = '0; ph_d = PH_LEN_PRE; end
            else ph_d = PH_FLAG;
          end
        end else begin
          ctrl_d = {ctrl_q[30:0], 1'b0};
          left_d = left_q - 6'd1;
          case (ph_q)
            PH_FLAG: begin
              pre_d = '0; ph_d = bit_v ? PH_GRP_PRE : PH_LIT_PRE;
            end
            PH_LIT_PRE, PH_GRP_PRE, PH_LEN_PRE: begin
              if (bit_v) begin
                if ({1'b0, pre_q} + 6'd1 >= 6'(MaxPrefix)) err_d = ST_PREFIX;
                else pre_d = pre_q + 5'd1;
              end else begin
                pre_d = pre_q + 5'd1; acc_d = {{(AccW-1){1'b0}}, 1'b1};
                ph_d = (ph_q == PH_LIT_PRE) ? PH_LIT_SUF :
                       (ph_q == PH_GRP_PRE) ? PH_GRP_SUF : PH_LEN_SUF;
              end
            end
            PH_LIT_SUF, PH_GRP_SUF, PH_LEN_SUF, PH_OFS: begin
              acc_d = acc_n; pre_d = pdec;
              if (pdec == 5'd0) begin
                case (ph_q)
                  PH_LIT_SUF: begin
                    run_d = vm1; ph_d = (vm1 != '0) ? PH_LIT_RUN : PH_FLAG;
                  end
                  PH_GRP_SUF: begin
                    grp_d = vm1; pre_d = '0;
                    ph_d = (vm1 != '0) ? PH_LEN_PRE : PH_FLAG;
                  end
                  PH_LEN_SUF: begin
                    run_d = vm1; acc_d = {{(AccW-1){1'b0}}, 1'b1};
                    pre_d = 5'(OffsetBits); ph_d = PH_OFS;
                  end
                  default: begin
                    ofs_d = o;
                    if (o == '0 || {21'd0, o} > emit_q) err_d = ST_OFFSET;
                    else if (run_q == '0) begin
                      grp_d = grp_q - 1'b1;
                      if (grp_d != '0) begin pre_d = '0; ph_d = PH_LEN_PRE; end
                      else ph_d = PH_FLAG;
                    end else ph_d = PH_COPY;
                  end
                endcase
              end
            end
            default: ph_d = PH_FLAG;
          endcase
        end
      end
    end
    res_d = '0;
    if (do_emit && {1'b0, emit_q} < total) begin
      res_d.out_valid = 1'b1;
      res_d.out_word  = emit_w;
      res_d.last      = ({1'b0, emit_q} + 32'd1 == total);
      res_d.out_bytes = (res_d.last && bytes_q[1:0] != 2'd0) ? {1'b0, bytes_q[1:0]} : 3'd4;
    end
    if (do_emit && emit_q != EmitMax) emit_d = emit_q + 31'd1;
    fin2 = (ph_d == PH_FLAG) && ({1'b0, emit_d} >= total);
    if (err_d != 3'd0) begin
      res_d.status = err_d;
    end else if (fin2) begin
      res_d.status = ST_DONE;
    end else begin
      res_d.need = want_f(ph_d, left_d, 1'b0);
    end
  end

  always_comb begin
    ram_we    = (seq_q == SQ_READ) && do_emit;
    ram_wdata = emit_w;
    ram_addr  = (seq_q == SQ_READ) ? emit_q[OffsetBits-1:0]
                                   : emit_q[OffsetBits-1:0] - ofs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE; bytes_q <= '0; ctrl_q <= '0; left_q <= '0; ph_q <= PH_FLAG;
      pre_q <= '0; acc_q <= '0; grp_q <= '0; run_q <= '0; ofs_q <= '0;
      emit_q <= '0; err_q <= '0;
    end else begin
      seq_q <= seq_d;
      if (cfg_if.valid) bytes_q <= cfg_if.data;
      if (seq_q == SQ_READ) begin
        ctrl_q <= ctrl_d; left_q <= left_d; ph_q <= ph_d; pre_q <= pre_d;
        acc_q <= acc_d; grp_q <= grp_d; run_q <= run_d; ofs_q <= ofs_d;
        emit_q <= emit_d; err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_q == SQ_IDLE && in_if.valid) item_q <= in_if.data;
    if (seq_q == SQ_READ) res_q <= res_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid) else $error("ready while result pending");
  a_read_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SQ_READ |=> out_if.valid) else $error("missing result");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(err_q) != 3'd0 |-> err_q == $past(err_q)) else $error("error cleared");
endmodule

### verif/tb_lz_word_decompressor_unit.sv
// Self-checking testbench for the LZ word decompressor, driving encoded streams.
`timescale 1ns / 1ps
module tb_lz_word_decompressor_unit;
  import lzwd_pkg::*;

  class lzwd_predictor;
    logic [31:0] nbytes;
    logic [31:0] ctl;
    int unsigned bits_left;
    phase_e      ph;
    int unsigned pcnt;
    logic [24:0] acc;
    logic [24:0] groups;
    logic [24:0] run;
    logic [9:0]  cofs;
    logic [30:0] emitted;
    logic [31:0] hist [HistDepth];
    logic [2:0]  err;
    out_t        pending [$];
    int unsigned fails;

    function new();
      nbytes = '0; ctl = '0; bits_left = 0; ph = PH_FLAG; pcnt = 0;
      acc = '0; groups = '0; run = '0; cofs = '0; emitted = '0; err = ST_RUN; fails = 0;
      foreach (hist[i]) hist[i] = '0;
    endfunction

    function longint total_words();
      return (longint'(nbytes) + 3) >> 2;
    endfunction

    function bit finished();
      return ph == PH_FLAG && longint'(emitted) >= total_words();
    endfunction

    function logic [1:0] wanted();
      if (err != ST_RUN || finished()) return CMD_TICK;
      if (ph == PH_LIT_RUN) return CMD_LIT;
      if (ph != PH_COPY && bits_left == 0) return CMD_CTRL;
      return CMD_TICK;
    endfunction

    function void emit(logic [31:0] w, ref out_t o);
      longint tot;
      tot = total_words();
      hist[emitted[9:0]] = w;
      if (longint'(emitted) < tot) begin
        o.out_valid = 1'b1;
        o.out_word  = w;
        o.out_bytes = 3'd4;
        if (longint'(emitted) + 1 == tot) begin
          o.last = 1'b1;
          if (nbytes[1:0] != 2'd0) o.out_bytes = {1'b0, nbytes[1:0]};
        end
      end
      if (emitted != EmitMax) emitted++;
    endfunction

    function void end_group();
      groups = groups - 1'b1;
      if (groups != 0) begin
        pcnt = 0;
        ph = PH_LEN_PRE;
      end else begin
        ph = PH_FLAG;
      end
    endfunction

    function void gamma_prefix(bit b, phase_e sfx);
      if (b) begin
        if (pcnt + 1 >= MaxPrefix) err = ST_PREFIX;
        else pcnt++;
      end else begin
        pcnt++;
        acc = 25'd1;
        ph = sfx;
      end
    endfunction

    function bit shift_field(bit b, output logic [24:0] v);
      acc = {acc[23:0], b};
      pcnt = (pcnt - 1) & 31;
      v = acc;
      return pcnt == 0;
    endfunction

    function void take_bit(bit b);
      logic [24:0] v;
      case (ph)
        PH_FLAG: begin
          pcnt = 0;
          ph = b ? PH_GRP_PRE : PH_LIT_PRE;
        end
        PH_LIT_PRE: gamma_prefix(b, PH_LIT_SUF);
        PH_GRP_PRE: gamma_prefix(b, PH_GRP_SUF);
        PH_LEN_PRE: gamma_prefix(b, PH_LEN_SUF);
        PH_LIT_SUF: if (shift_field(b, v)) begin
          run = v - 1'b1;
          ph = (run != 0) ? PH_LIT_RUN : PH_FLAG;
        end
        PH_GRP_SUF: if (shift_field(b, v)) begin
          groups = v - 1'b1;
          pcnt = 0;
          ph = (groups != 0) ? PH_LEN_PRE : PH_FLAG;
        end
        PH_LEN_SUF: if (shift_field(b, v)) begin
          run = v - 1'b1;
          acc = 25'd1;
          pcnt = OffsetBits;
          ph = PH_OFS;
        end
        PH_OFS: if (shift_field(b, v)) begin
          cofs = v[9:0];
          if (cofs == 0 || 31'(cofs) > emitted) err = ST_OFFSET;
          else if (run == 0) end_group();
          else ph = PH_COPY;
        end
        default: ph = PH_FLAG;
      endcase
    endfunction

    function void note_item(logic [1:0] cmd, logic [31:0] w);
      out_t o;
      bit done;
      logic [1:0] want;
      o = '0;
      if (err == ST_RUN) begin
        done = finished();
        want = wanted();
        if (cmd == CMD_CTRL || cmd == CMD_LIT) begin
          if (cmd != want) begin
            err = ST_KIND;
          end else if (cmd == CMD_CTRL) begin
            ctl = w;
            bits_left = 32;
          end else begin
            emit(w, o);
            run = run - 1'b1;
            if (run == 0) ph = PH_FLAG;
          end
        end else if (cmd == CMD_TICK && !done && want == CMD_TICK) begin
          if (ph == PH_COPY) begin
            emit(hist[10'(emitted[9:0] - cofs)], o);
            run = run - 1'b1;
            if (run == 0) end_group();
          end else begin
            bits_left--;
            take_bit(ctl[31]);
            ctl = ctl << 1;
          end
        end
      end
      o.need = wanted();
      if (err != ST_RUN) o.status = err;
      else if (finished()) o.status = ST_DONE;
      else o.status = ST_RUN;
      pending.push_back(o);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("Result beat with nothing expected: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.out_valid !== exp.out_valid || got.out_word !== exp.out_word ||
          got.out_bytes !== exp.out_bytes || got.last !== exp.last ||
          got.need !== exp.need || got.status !== exp.status) begin
        fails++;
        if (fails <= 10) $display("Mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  lzwd_in_if  in_ch ();
  lzwd_out_if out_ch ();
  lzwd_cfg_if cfg_ch ();

  lz_word_decompressor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lzwd_predictor decoder_model = new();
  int unsigned   src_idle;
  int unsigned   snk_idle;
  int unsigned   sent;
  bit            ctl_bits [$];
  logic [31:0]   lit_words [$];
  longint        enc_emitted;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
    if (out_ch.valid && out_ch.ready) decoder_model.check_result(out_ch.data);
  end

  function void put_bits(int unsigned value, int n);
    for (int i = n - 1; i >= 0; i--) ctl_bits.push_back(value[i]);
  endfunction

  function void put_gamma(int unsigned count);
    int k;
    k = $clog2(count + 2) - 1;
    for (int i = 0; i < k - 1; i++) ctl_bits.push_back(1'b1);
    ctl_bits.push_back(1'b0);
    put_bits(count + 1, k);
  endfunction

  function int unsigned rand_count();
    if ($urandom_range(19) == 0) return $urandom_range(7, 60);
    return $urandom_range(1, 6);
  endfunction

  function void put_token();
    int unsigned cnt;
    int unsigned ofs;
    int unsigned far;
    if (enc_emitted == 0 || $urandom_range(1) == 0) begin
      cnt = rand_count();
      ctl_bits.push_back(1'b0);
      put_gamma(cnt);
      repeat (cnt) begin
        case ($urandom_range(9))
          0: lit_words.push_back(32'h0000_0000);
          1: lit_words.push_back(32'hFFFF_FFFF);
          default: lit_words.push_back($urandom);
        endcase
      end
      enc_emitted += cnt;
    end else begin
      ctl_bits.push_back(1'b1);
      cnt = $urandom_range(1, 3);
      put_gamma(cnt);
      repeat (cnt) begin
        far = (enc_emitted > 1023) ? 1023 : int'(enc_emitted);
        ofs = ($urandom_range(7) == 0) ? far : $urandom_range(1, far);
        cnt = rand_count();
        put_gamma(cnt);
        put_bits(ofs, OffsetBits);
        enc_emitted += cnt;
      end
    end
  endfunction

  function logic [31:0] next_ctl_word();
    logic [31:0] w;
    while (ctl_bits.size() < 32) put_token();
    for (int i = 31; i >= 0; i--) w[i] = ctl_bits.pop_front();
    return w;
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data.command <= cmd;
    in_ch.data.word    <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    decoder_model.note_item(cmd, w);
    sent++;
  endtask

  task automatic drive_one();
    logic [1:0] want;
    want = decoder_model.wanted();
    if ($urandom_range(19) == 0) send(CMD_NONE, $urandom);
    else if (want != CMD_TICK && $urandom_range(19) == 0) send(CMD_TICK, $urandom);
    else if (want == CMD_CTRL) send(CMD_CTRL, next_ctl_word());
    else if (want == CMD_LIT) send(CMD_LIT, lit_words.pop_front());
    else send(CMD_TICK, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (decoder_model.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    decoder_model.nbytes = value;
  endtask

  initial begin
    longint words;
    logic [1:0] want;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    src_idle = 21;
    snk_idle = 85;
    sent = 0;
    enc_emitted = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(32'd0);
    send(CMD_TICK, 32'hFFFF_FFFF);
    send(CMD_NONE, 32'h0000_0000);
    drain();
    write_size(32'd1);
    while (!decoder_model.finished()) drive_one();

    while (sent < 1750) begin
      drain();
      if (sent >= 1166) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (sent >= 583) begin
        src_idle = 85;
        snk_idle = 21;
      end
      words = longint'(decoder_model.emitted) + $urandom_range(1, 30);
      write_size(32'(words * 4 - $urandom_range(0, 3)));
      while (!decoder_model.finished()) drive_one();
    end

    drain();
    write_size(32'hFFFF_FFFF);
    repeat (30) drive_one();
    case ($urandom_range(2))
      0: begin
        want = decoder_model.wanted();
        send((want == CMD_CTRL) ? CMD_LIT : CMD_CTRL, $urandom);
      end
      1: begin
        ctl_bits.push_back(1'b0);
        repeat (MaxPrefix) ctl_bits.push_back(1'b1);
      end
      default: begin
        ctl_bits.push_back(1'b1);
        put_gamma(1);
        put_gamma(1);
        put_bits(0, OffsetBits);
      end
    endcase
    while (decoder_model.err == ST_RUN) drive_one();
    send(CMD_TICK, $urandom);
    send(CMD_CTRL, $urandom);
    send(CMD_LIT, $urandom);
    drain();
    repeat (10) @(posedge clk_i);
    if (decoder_model.fails == 0 && decoder_model.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

### lz_word_decompressor_unit.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_if.sv
hw/rtl/lzwd_ram.sv
hw/rtl/lz_word_decompressor_unit.sv
verif/tb_lz_word_decompressor_unit.sv
